### rtl/rhg_pkg.sv
// Shared types and constants for the RGB histogram with grayscale conversion.
// Used by every module of the block; depends on nothing else.
package rhg_pkg;

  localparam int SAMPLE_W = 8;
  localparam int OP_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int WEIGHT_W = 8;
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int OUT_COUNT_W = 32;

  localparam int DEF_BIN_COUNT = 256;
  localparam int DEF_COUNT_BITS = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_WEIGHT = 2'd2;

  localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RST = 8'd54;
  localparam logic [WEIGHT_W-1:0] GREEN_WEIGHT_RST = 8'd184;
  localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RST = 8'd18;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] gray;
    logic [SAMPLE_W-1:0] bin_index;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_status_t;

endpackage

### rtl/rhg_front.sv
// Front end: takes requests and weight writes, forms the gray value.
// Depends on rhg_pkg; feeds rhg_queue.
module rhg_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rhg_pkg::OP_W-1:0]        in_op,
  input  logic [rhg_pkg::SAMPLE_W-1:0]    in_red_in,
  input  logic [rhg_pkg::SAMPLE_W-1:0]    in_green_in,
  input  logic [rhg_pkg::SAMPLE_W-1:0]    in_blue_in,
  input  logic [rhg_pkg::SAMPLE_W-1:0]    in_bin_index,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rhg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rhg_pkg::WEIGHT_W-1:0]    cfg_data,
  input  logic                            clearing,
  input  logic                            q_full,
  output logic                            q_push,
  output rhg_pkg::item_t                  q_item
);

  logic [rhg_pkg::WEIGHT_W-1:0] red_weight_r, green_weight_r, blue_weight_r;
  logic                         stage_valid_r;
  logic [rhg_pkg::PROD_W-1:0]   red_prod_r, green_prod_r, blue_prod_r;
  logic [rhg_pkg::OP_W-1:0]     op_r;
  logic [rhg_pkg::SAMPLE_W-1:0] red_r, green_r, blue_r, idx_r;
  logic                         stage_ready;
  logic                         accept;
  logic [rhg_pkg::SUM_W-1:0]    sum;
  logic [rhg_pkg::SUM_W-9:0]    scaled;
  logic [rhg_pkg::SAMPLE_W-1:0] gray;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_weight_r   <= rhg_pkg::RED_WEIGHT_RST;
      green_weight_r <= rhg_pkg::GREEN_WEIGHT_RST;
      blue_weight_r  <= rhg_pkg::BLUE_WEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rhg_pkg::CFG_RED_WEIGHT:   red_weight_r <= cfg_data;
        rhg_pkg::CFG_GREEN_WEIGHT: green_weight_r <= cfg_data;
        rhg_pkg::CFG_BLUE_WEIGHT:  blue_weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign stage_ready = !stage_valid_r || !q_full;
  assign in_stall = clearing || !stage_ready;
  assign accept = in_valid && !in_stall;
  assign q_push = stage_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (accept) begin
      stage_valid_r <= 1'b1;
    end else if (q_push) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_prod_r   <= rhg_pkg::PROD_W'(red_weight_r) * rhg_pkg::PROD_W'(in_red_in);
      green_prod_r <= rhg_pkg::PROD_W'(green_weight_r) * rhg_pkg::PROD_W'(in_green_in);
      blue_prod_r  <= rhg_pkg::PROD_W'(blue_weight_r) * rhg_pkg::PROD_W'(in_blue_in);
      op_r         <= in_op;
      red_r        <= in_red_in;
      green_r      <= in_green_in;
      blue_r       <= in_blue_in;
      idx_r        <= in_bin_index;
    end
  end

  always_comb begin
    sum = rhg_pkg::SUM_W'(red_prod_r) + rhg_pkg::SUM_W'(green_prod_r)
        + rhg_pkg::SUM_W'(blue_prod_r);
    scaled = sum[rhg_pkg::SUM_W-1:8];
    gray = (|scaled[rhg_pkg::SUM_W-9:8]) ? 8'hFF : scaled[7:0];
  end

  always_comb begin
    q_item.op        = op_r;
    q_item.red       = red_r;
    q_item.green     = green_r;
    q_item.blue      = blue_r;
    q_item.gray      = (op_r == rhg_pkg::OP_PIXEL) ? gray : '0;
    q_item.bin_index = idx_r;
  end

endmodule

### rtl/rhg_queue.sv
// Short request queue between the front end and the histogram back end.
// Depends on rhg_pkg for the item type and depth.
module rhg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rhg_pkg::item_t push_item,
  input  logic           pop,
  output rhg_pkg::item_t head,
  output logic           empty,
  output logic           full
);

  rhg_pkg::item_t                  slots_r [rhg_pkg::QUEUE_DEPTH];
  logic [rhg_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rhg_pkg::QUEUE_CNT_W-1:0] count_r;

  assign empty = (count_r == '0);
  assign full = (count_r == rhg_pkg::QUEUE_CNT_W'(rhg_pkg::QUEUE_DEPTH));
  assign head = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/rhg_back.sv
// Back end: four histogram memories, read-modify-write sequencer and result register.
// Depends on rhg_pkg; takes requests from rhg_queue.
module rhg_back #(
  parameter int BIN_COUNT  = rhg_pkg::DEF_BIN_COUNT,
  parameter int COUNT_BITS = rhg_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rhg_pkg::item_t                    head,
  input  logic                              q_empty,
  output rhg_pkg::back_status_t             status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rhg_pkg::SAMPLE_W-1:0]      out_gray_level,
  output logic [rhg_pkg::OUT_COUNT_W-1:0]   out_red_count,
  output logic [rhg_pkg::OUT_COUNT_W-1:0]   out_green_count,
  output logic [rhg_pkg::OUT_COUNT_W-1:0]   out_blue_count,
  output logic [rhg_pkg::OUT_COUNT_W-1:0]   out_gray_count
);

  localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BIN_W-1:0] addr_t;

  count_t red_mem [BIN_COUNT];
  count_t green_mem [BIN_COUNT];
  count_t blue_mem [BIN_COUNT];
  count_t gray_mem [BIN_COUNT];

  state_t         state_r, state_nxt;
  addr_t          clr_cnt_r;
  rhg_pkg::item_t cur_r;
  count_t         red_rd_r, green_rd_r, blue_rd_r, gray_rd_r;
  logic           out_valid_r;
  logic           out_free;
  logic           pop;
  logic           exec_fire;
  logic           cur_in_range;
  logic           wr_en;
  addr_t          rd_red, rd_green, rd_blue, rd_gray;
  addr_t          wa_red, wa_green, wa_blue, wa_gray;
  count_t         wd_red, wd_green, wd_blue, wd_gray;

  function automatic addr_t bin_of(input logic [rhg_pkg::SAMPLE_W-1:0] v);
    if ({1'b0, v} >= 9'(BIN_COUNT)) begin
      return BIN_W'(BIN_COUNT - 1);
    end
    return v[BIN_W-1:0];
  endfunction

  function automatic addr_t pick(input logic [rhg_pkg::OP_W-1:0] op,
                                 input logic [rhg_pkg::SAMPLE_W-1:0] sample,
                                 input logic [rhg_pkg::SAMPLE_W-1:0] idx);
    if (op == rhg_pkg::OP_PIXEL) begin
      return bin_of(sample);
    end
    return idx[BIN_W-1:0];
  endfunction

  function automatic count_t bump(input count_t c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [rhg_pkg::OUT_COUNT_W-1:0] report(input count_t c);
    logic [63:0] e;
    e = 64'(c);
    if (e > 64'(32'hFFFF_FFFF)) begin
      return 32'hFFFF_FFFF;
    end
    return e[rhg_pkg::OUT_COUNT_W-1:0];
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign pop = (state_r == S_IDLE) && !q_empty;
  assign exec_fire = (state_r == S_EXEC) && out_free;
  assign cur_in_range = {1'b0, cur_r.bin_index} < 9'(BIN_COUNT);
  assign status.clearing = (state_r == S_CLEAR);
  assign status.pop = pop;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == BIN_W'(BIN_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    rd_red   = pick(head.op, head.red, head.bin_index);
    rd_green = pick(head.op, head.green, head.bin_index);
    rd_blue  = pick(head.op, head.blue, head.bin_index);
    rd_gray  = pick(head.op, head.gray, head.bin_index);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= head;
      red_rd_r   <= red_mem[rd_red];
      green_rd_r <= green_mem[rd_green];
      blue_rd_r  <= blue_mem[rd_blue];
      gray_rd_r  <= gray_mem[rd_gray];
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wa_red   = pick(cur_r.op, cur_r.red, cur_r.bin_index);
    wa_green = pick(cur_r.op, cur_r.green, cur_r.bin_index);
    wa_blue  = pick(cur_r.op, cur_r.blue, cur_r.bin_index);
    wa_gray  = pick(cur_r.op, cur_r.gray, cur_r.bin_index);
    wd_red   = '0;
    wd_green = '0;
    wd_blue  = '0;
    wd_gray  = '0;
    if (state_r == S_CLEAR) begin
      wr_en    = 1'b1;
      wa_red   = clr_cnt_r;
      wa_green = clr_cnt_r;
      wa_blue  = clr_cnt_r;
      wa_gray  = clr_cnt_r;
    end else if (exec_fire) begin
      if (cur_r.op == rhg_pkg::OP_PIXEL) begin
        wr_en    = 1'b1;
        wd_red   = bump(red_rd_r);
        wd_green = bump(green_rd_r);
        wd_blue  = bump(blue_rd_r);
        wd_gray  = bump(gray_rd_r);
      end else if (cur_r.op == rhg_pkg::OP_CLEAR) begin
        wr_en = cur_in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      red_mem[wa_red]     <= wd_red;
      green_mem[wa_green] <= wd_green;
      blue_mem[wa_blue]   <= wd_blue;
      gray_mem[wa_gray]   <= wd_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_gray_level  <= (cur_r.op == rhg_pkg::OP_PIXEL) ? cur_r.gray : '0;
      out_red_count   <= '0;
      out_green_count <= '0;
      out_blue_count  <= '0;
      out_gray_count  <= '0;
      if (cur_r.op == rhg_pkg::OP_READ && cur_in_range) begin
        out_red_count   <= report(red_rd_r);
        out_green_count <= report(green_rd_r);
        out_blue_count  <= report(blue_rd_r);
        out_gray_count  <= report(gray_rd_r);
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/rgb_histogram_grayscale_core.sv
// RGB histogram with grayscale conversion, top level.
// Path: a request is registered in the front stage, queued, and read with its bin counts;
// its result is then registered. A new request waits for the read then write of the bins.
// Reset: weights return to 54/184/18; a clearing pass then zeroes all bins, and no request
// is accepted during it. Weight writes are taken at any time.
module rgb_histogram_grayscale_core #(
  parameter int BIN_COUNT  = rhg_pkg::DEF_BIN_COUNT,
  parameter int COUNT_BITS = rhg_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rhg_pkg::OP_W-1:0]          in_op,
  input  logic [rhg_pkg::SAMPLE_W-1:0]      in_red_in,
  input  logic [rhg_pkg::SAMPLE_W-1:0]      in_green_in,
  input  logic [rhg_pkg::SAMPLE_W-1:0]      in_blue_in,
  input  logic [rhg_pkg::SAMPLE_W-1:0]      in_bin_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rhg_pkg::SAMPLE_W-1:0]      out_gray_level,
  output logic [rhg_pkg::OUT_COUNT_W-1:0]   out_red_count,
  output logic [rhg_pkg::OUT_COUNT_W-1:0]   out_green_count,
  output logic [rhg_pkg::OUT_COUNT_W-1:0]   out_blue_count,
  output logic [rhg_pkg::OUT_COUNT_W-1:0]   out_gray_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rhg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rhg_pkg::WEIGHT_W-1:0]      cfg_data
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_empty;
  rhg_pkg::item_t        q_item;
  rhg_pkg::item_t        q_head;
  rhg_pkg::back_status_t bk_status;

  rhg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_bin_index (in_bin_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .clearing     (bk_status.clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  rhg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (bk_status.pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rhg_back #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_empty         (q_empty),
    .status          (bk_status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gray_level  (out_gray_level),
    .out_red_count   (out_red_count),
    .out_green_count (out_green_count),
    .out_blue_count  (out_blue_count),
    .out_gray_count  (out_gray_count)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("Request pushed into a full queue.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.pop |-> !q_empty)
    else $error("Request popped from an empty queue.");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.clearing |-> !(in_valid && !in_stall))
    else $error("Request accepted during the clearing pass.");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.clearing |-> !bk_status.pop)
    else $error("Back end started a request during the clearing pass.");
`endif

endmodule

### test/rhg_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB histogram core: watches the request, result and weight channels.
// Keeps its own weights and four histograms, predicts each result and compares it.
// Depends on rhg_pkg for widths, operation codes and register indexes.
module rhg_checker
  import rhg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [OP_W-1:0]        in_op,
  input  logic [SAMPLE_W-1:0]    in_red_in,
  input  logic [SAMPLE_W-1:0]    in_green_in,
  input  logic [SAMPLE_W-1:0]    in_blue_in,
  input  logic [SAMPLE_W-1:0]    in_bin_index,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [SAMPLE_W-1:0]    out_gray_level,
  input  logic [OUT_COUNT_W-1:0] out_red_count,
  input  logic [OUT_COUNT_W-1:0] out_green_count,
  input  logic [OUT_COUNT_W-1:0] out_blue_count,
  input  logic [OUT_COUNT_W-1:0] out_gray_count,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WEIGHT_W-1:0]    cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int BIN_N = DEF_BIN_COUNT;
  localparam int COUNT_W = DEF_COUNT_BITS;

  typedef struct packed {
    logic [SAMPLE_W-1:0]    gray_level;
    logic [OUT_COUNT_W-1:0] red_count;
    logic [OUT_COUNT_W-1:0] green_count;
    logic [OUT_COUNT_W-1:0] blue_count;
    logic [OUT_COUNT_W-1:0] gray_count;
  } bin_reply_t;

  logic [WEIGHT_W-1:0] red_w = RED_WEIGHT_RST;
  logic [WEIGHT_W-1:0] green_w = GREEN_WEIGHT_RST;
  logic [WEIGHT_W-1:0] blue_w = BLUE_WEIGHT_RST;
  logic [COUNT_W-1:0]  red_hist [BIN_N];
  logic [COUNT_W-1:0]  green_hist [BIN_N];
  logic [COUNT_W-1:0]  blue_hist [BIN_N];
  logic [COUNT_W-1:0]  gray_hist [BIN_N];
  bin_reply_t          replies_due [$];
  bin_reply_t          got;
  bin_reply_t          want;
  int                  fails = 0;

  function automatic int unsigned bin_of(logic [SAMPLE_W-1:0] v);
    return (v >= BIN_N) ? BIN_N - 1 : v;
  endfunction

  function automatic logic [COUNT_W-1:0] bumped(logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic bin_reply_t histogram_step(logic [OP_W-1:0] op,
                                                logic [SAMPLE_W-1:0] r,
                                                logic [SAMPLE_W-1:0] g,
                                                logic [SAMPLE_W-1:0] b,
                                                logic [SAMPLE_W-1:0] bin);
    bin_reply_t          rep;
    int unsigned         sum;
    logic [SAMPLE_W-1:0] gray;
    rep = '0;
    case (op)
      OP_PIXEL: begin
        sum = 32'(red_w) * 32'(r) + 32'(green_w) * 32'(g) + 32'(blue_w) * 32'(b);
        gray = (sum > 32'hFFFF) ? '1 : sum[15:8];
        red_hist[bin_of(r)] = bumped(red_hist[bin_of(r)]);
        green_hist[bin_of(g)] = bumped(green_hist[bin_of(g)]);
        blue_hist[bin_of(b)] = bumped(blue_hist[bin_of(b)]);
        gray_hist[bin_of(gray)] = bumped(gray_hist[bin_of(gray)]);
        rep.gray_level = gray;
      end
      OP_READ: begin
        if (bin < BIN_N) begin
          rep.red_count = red_hist[bin];
          rep.green_count = green_hist[bin];
          rep.blue_count = blue_hist[bin];
          rep.gray_count = gray_hist[bin];
        end
      end
      OP_CLEAR: begin
        if (bin < BIN_N) begin
          red_hist[bin] = '0;
          green_hist[bin] = '0;
          blue_hist[bin] = '0;
          gray_hist[bin] = '0;
        end
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  task automatic note_failure(string what, bin_reply_t exp_r, bin_reply_t act_r);
    if (fails < 10) begin
      $display("%s: expected gray %0d counts %0d/%0d/%0d/%0d, got gray %0d counts %0d/%0d/%0d/%0d",
               what, exp_r.gray_level, exp_r.red_count, exp_r.green_count, exp_r.blue_count,
               exp_r.gray_count, act_r.gray_level, act_r.red_count, act_r.green_count,
               act_r.blue_count, act_r.gray_count);
    end
    fails++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      red_w = RED_WEIGHT_RST;
      green_w = GREEN_WEIGHT_RST;
      blue_w = BLUE_WEIGHT_RST;
      for (int i = 0; i < BIN_N; i++) begin
        red_hist[i] = '0;
        green_hist[i] = '0;
        blue_hist[i] = '0;
        gray_hist[i] = '0;
      end
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.gray_level = out_gray_level;
        got.red_count = out_red_count;
        got.green_count = out_green_count;
        got.blue_count = out_blue_count;
        got.gray_count = out_gray_count;
        if (replies_due.size() == 0) begin
          note_failure("result with no request waiting", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got.gray_level !== want.gray_level || got.red_count !== want.red_count ||
              got.green_count !== want.green_count || got.blue_count !== want.blue_count ||
              got.gray_count !== want.gray_count) begin
            note_failure("result mismatch", want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RED_WEIGHT:   red_w = cfg_data;
          CFG_GREEN_WEIGHT: green_w = cfg_data;
          CFG_BLUE_WEIGHT:  blue_w = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        replies_due.push_back(histogram_step(in_op, in_red_in, in_green_in, in_blue_in,
                                             in_bin_index));
      end
    end
    pending <= replies_due.size();
    fail_count <= fails;
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the RGB histogram core: drives pixel, read and clear requests
// and weight writes, stalls the result side, and gives the verdict from rhg_checker.
// Depends on rhg_pkg, rhg_checker and the core itself.
module tb_top;
  import rhg_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 135;
  localparam int PHASES = 8;
  localparam int HOLD_CYCLES = 60;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        in_op;
  logic [SAMPLE_W-1:0]    in_red_in;
  logic [SAMPLE_W-1:0]    in_green_in;
  logic [SAMPLE_W-1:0]    in_blue_in;
  logic [SAMPLE_W-1:0]    in_bin_index;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SAMPLE_W-1:0]    out_gray_level;
  logic [OUT_COUNT_W-1:0] out_red_count;
  logic [OUT_COUNT_W-1:0] out_green_count;
  logic [OUT_COUNT_W-1:0] out_blue_count;
  logic [OUT_COUNT_W-1:0] out_gray_count;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [WEIGHT_W-1:0]    cfg_data;
  int                     fail_count;
  int                     pending;
  bit                     idle_on = 1'b1;
  bit                     hold_req = 1'b0;
  bit                     hold_done = 1'b0;

  always #1 clk = ~clk;

  rgb_histogram_grayscale_core u_top (.*);

  rhg_checker u_checker (.*);

  initial begin
    #500000;
    $display("tb: failure");
    $finish;
  end

  // The result side stalls in short random bursts, and once for a long stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] r,
                              input logic [SAMPLE_W-1:0] g, input logic [SAMPLE_W-1:0] b,
                              input logic [SAMPLE_W-1:0] bin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_bin_index <= bin;
    do @(posedge clk); while (in_stall);
  endtask

  // Half of the samples fall near the ends so that bins repeat back to back.
  function automatic logic [SAMPLE_W-1:0] random_sample();
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, 255));
    end else if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, 7));
    end else begin
      return 8'($urandom_range(248, 255));
    end
  endfunction

  task automatic send_random_request();
    int unsigned     pick;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      op = OP_PIXEL;
    end else if (pick < 85) begin
      op = OP_READ;
    end else if (pick < 95) begin
      op = OP_CLEAR;
    end else begin
      op = OP_UNUSED;
    end
    send_request(op, random_sample(), random_sample(), random_sample(), random_sample());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_weight(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // The write to the unused index comes last, so a wrong decode shows up in the blue weight.
  task automatic set_weights(input logic [WEIGHT_W-1:0] wr, input logic [WEIGHT_W-1:0] wg,
                             input logic [WEIGHT_W-1:0] wb);
    wait_drained();
    write_weight(CFG_RED_WEIGHT, wr);
    write_weight(CFG_GREEN_WEIGHT, wg);
    write_weight(CFG_BLUE_WEIGHT, wb);
    write_weight(CFG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_PIXEL;
    in_red_in <= '0;
    in_green_in <= '0;
    in_blue_in <= '0;
    in_bin_index <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RED_WEIGHT;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
    send_request(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
    send_request(OP_PIXEL, 8'h55, 8'hAA, 8'h0F, 8'd0);
    send_request(OP_PIXEL, 8'hAA, 8'h55, 8'hF0, 8'd0);
    send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255);
    send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'hAA);
    send_request(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd255);
    send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255);
    send_request(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(OP_PIXEL, 8'd128, 8'd128, 8'd128, 8'd0);
    send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd128);

    set_weights(8'd255, 8'd255, 8'd255);
    send_request(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
    send_request(OP_PIXEL, 8'd1, 8'd1, 8'd1, 8'd0);
    send_request(OP_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0);
    send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd255);

    set_weights(8'd0, 8'd0, 8'd0);
    send_request(OP_PIXEL, 8'd200, 8'd100, 8'd50, 8'd0);
    send_request(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: set_weights(8'd255, 8'd255, 8'd255);
        2: set_weights(8'd0, 8'd0, 8'd0);
        4: set_weights(8'd255, 8'd0, 8'd0);
        6: set_weights(8'd0, 8'd0, 8'd255);
        PHASES - 1: set_weights(RED_WEIGHT_RST, GREEN_WEIGHT_RST, BLUE_WEIGHT_RST);
        default: set_weights(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
      endcase
      if (p == 2) begin
        hold_req <= 1'b1;
      end
      if (p == PHASES - 1) begin
        idle_on <= 1'b0;
      end
      repeat (PHASE_ITEMS) send_random_request();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rhg_pkg.sv
rtl/rhg_front.sv
rtl/rhg_queue.sv
rtl/rhg_back.sv
rtl/rgb_histogram_grayscale_core.sv
test/rhg_checker.sv
test/tb_top.sv
